// File: sv/epoch_seconds_to_calendar_top_defines.svh
// Assertion macros shared by the epoch-to-calendar checker.
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define ES2C_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("es2c checker: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define ES2C_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("es2c checker: same-cycle property failed");

`endif

// File: sv/es2c_pkg.sv
// Shared types, constants and the month length table for the epoch-to-calendar block.
`default_nettype none
package es2c_pkg;

    localparam int SECONDS_BITS_DEF = 31;
    localparam int SECS_PER_DAY     = 86400;
    localparam int SECS_PER_HOUR    = 3600;
    localparam int SECS_PER_MIN     = 60;
    localparam int TOD_W            = 17;
    localparam int CNT_W            = 5;
    localparam logic [10:0] EPOCH_YEAR    = 11'd1970;
    localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
    localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
    localparam logic [3:0]  MONTH_JAN     = 4'd1;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DDIV  = 8'b0000_0010,
        S_WDIV  = 8'b0000_0100,
        S_YEAR  = 8'b0000_1000,
        S_MONTH = 8'b0001_0000,
        S_HDIV  = 8'b0010_0000,
        S_MDIV  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [2:0]  weekday;
        logic [8:0]  day_of_year;
    } t_cal;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_stat;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd4:      len = 5'd30;
            4'd6:      len = 5'd30;
            4'd9:      len = 5'd30;
            4'd11:     len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

// File: sv/es2c_sub.sv
// Shared compare-and-subtract unit used by every step of the converter.
`default_nettype none
module es2c_sub #(
    parameter int W = 31
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic      [W-1:0] o_diff,
    output logic              o_borrow
);

    logic [W:0] full;

    // A borrow out of the top bit means i_a is less than i_b.
    assign full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = full[W-1:0];
    assign o_borrow = full[W];

endmodule
`default_nettype wire

// File: sv/es2c_core.sv
// Sequencer and working registers that drive the shared subtract unit.
`default_nettype none
module es2c_core
    import es2c_pkg::*;
#(
    parameter int SECONDS_BITS = SECONDS_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [SECONDS_BITS-1:0] i_secs,
    input  wire logic                    i_take,
    output t_core_stat                   o_stat,
    output t_cal                         o_res
);

    localparam int W      = SECONDS_BITS;
    localparam int DAYS_W = SECONDS_BITS - 16;

    t_state             r_state, n_state;
    logic [W-1:0]       r_rem, n_rem;
    logic [W-1:0]       r_dvs, n_dvs;
    logic [W-1:0]       r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DAYS_W-1:0]  r_days, n_days;
    logic [TOD_W-1:0]   r_tod, n_tod;
    logic [1:0]         r_m4, n_m4;
    logic [6:0]         r_m100, n_m100;
    logic [8:0]         r_m400, n_m400;
    t_cal               r_res, n_res;

    logic [W-1:0] sub_b;
    logic [W-1:0] sub_diff;
    logic         sub_borrow;
    logic [W-1:0] rem_step;
    logic [W-1:0] quo_step;
    logic         leap;
    logic [2:0]   r7;

    es2c_sub #(.W(W)) u_sub (
        .i_a      (r_rem),
        .i_b      (sub_b),
        .o_diff   (sub_diff),
        .o_borrow (sub_borrow)
    );

    assign leap     = (r_m400 == 9'd0) || ((r_m100 != 7'd0) && (r_m4 == 2'd0));
    assign rem_step = sub_borrow ? r_rem : sub_diff;
    assign quo_step = {r_quo[W-2:0], ~sub_borrow};
    assign r7       = rem_step[2:0];

    always_comb begin
        case (r_state)
            S_YEAR:  sub_b = leap ? W'(366) : W'(365);
            S_MONTH: sub_b = W'(month_days(r_res.month, leap));
            default: sub_b = r_dvs;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_days  = r_days;
        n_tod   = r_tod;
        n_m4    = r_m4;
        n_m100  = r_m100;
        n_m400  = r_m400;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_rem   = i_secs;
                    n_dvs   = W'(SECS_PER_DAY) << (DAYS_W - 1);
                    n_cnt   = CNT_W'(DAYS_W - 1);
                    n_quo   = '0;
                    n_state = S_DDIV;
                end
            end
            S_DDIV: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_days  = quo_step[DAYS_W-1:0];
                    n_tod   = rem_step[TOD_W-1:0];
                    n_rem   = W'(quo_step[DAYS_W-1:0]);
                    n_dvs   = W'(7) << (DAYS_W - 3);
                    n_cnt   = CNT_W'(DAYS_W - 3);
                    n_state = S_WDIV;
                end
            end
            S_WDIV: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    // The epoch fell on a Thursday, so shift the remainder by four.
                    n_res.weekday = (r7 >= 3'd3) ? (r7 - 3'd3) : (r7 + EPOCH_WEEKDAY);
                    n_rem         = W'(r_days);
                    n_res.year    = EPOCH_YEAR;
                    n_m4          = EPOCH_MOD4;
                    n_m100        = EPOCH_MOD100;
                    n_m400        = EPOCH_MOD400;
                    n_state       = S_YEAR;
                end
            end
            S_YEAR: begin
                if (sub_borrow) begin
                    n_res.day_of_year = r_rem[8:0];
                    n_res.month       = MONTH_JAN;
                    n_state           = S_MONTH;
                end else begin
                    n_rem      = sub_diff;
                    n_res.year = r_res.year + 11'd1;
                    n_m4       = r_m4 + 2'd1;
                    n_m100     = (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
                    n_m400     = (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
                end
            end
            S_MONTH: begin
                if (sub_borrow || (r_res.month == MONTH_DEC)) begin
                    n_res.day_of_month = r_rem[4:0] + 5'd1;
                    n_rem              = W'(r_tod);
                    n_dvs              = W'(SECS_PER_HOUR) << 4;
                    n_cnt              = CNT_W'(4);
                    n_state            = S_HDIV;
                end else begin
                    n_rem       = sub_diff;
                    n_res.month = r_res.month + 4'd1;
                end
            end
            S_HDIV: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_res.hour = quo_step[4:0];
                    n_dvs      = W'(SECS_PER_MIN) << 5;
                    n_cnt      = CNT_W'(5);
                    n_state    = S_MDIV;
                end
            end
            S_MDIV: begin
                n_rem = rem_step;
                n_quo = quo_step;
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_res.minute = quo_step[5:0];
                    n_res.second = rem_step[5:0];
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quo  <= n_quo;
        r_cnt  <= n_cnt;
        r_days <= n_days;
        r_tod  <= n_tod;
        r_m4   <= n_m4;
        r_m100 <= n_m100;
        r_m400 <= n_m400;
        r_res  <= n_res;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule
`default_nettype wire

// File: sv/epoch_seconds_to_calendar_top.sv
// Top level of the epoch seconds to calendar converter with its output register.
//
//   Channel | Direction | Handshake                  | Word
//   --------+-----------+----------------------------+-----------------------------
//   in      | input     | i_in_valid / o_in_ready    | i_epoch_seconds
//   out     | output    | o_out_valid / i_out_ready  | o_year .. o_day_of_year
//
// A word shows at the output once the sequencer has run all its steps, and the input is
// ready again in that same cycle. One shared subtractor runs four restoring divisions
// and the year and month count-down loops, one step per cycle.
// Reset is synchronous and active low; it idles the sequencer and empties the output.
// The input waits while the sequencer is busy or holds a word that a stalled reader blocks.
`default_nettype none
module epoch_seconds_to_calendar_top
    import es2c_pkg::*;
#(
    parameter int SECONDS_BITS = SECONDS_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [SECONDS_BITS-1:0] i_epoch_seconds,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [10:0]                  o_year,
    output logic [3:0]                   o_month,
    output logic [4:0]                   o_day_of_month,
    output logic [4:0]                   o_hour,
    output logic [5:0]                   o_minute,
    output logic [5:0]                   o_second,
    output logic [2:0]                   o_weekday,
    output logic [8:0]                   o_day_of_year
);

    t_core_stat core_stat;
    t_cal       core_res;
    logic       start;
    logic       load;
    logic       r_out_valid, n_out_valid;
    t_cal       r_out, n_out;

    // The sequencer starts as soon as a word is accepted.
    assign start = i_in_valid && o_in_ready;

    // A finished result moves out when the output register is free this cycle.
    assign load = core_stat.done && (!r_out_valid || i_out_ready);

    es2c_core #(.SECONDS_BITS(SECONDS_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_secs  (i_epoch_seconds),
        .i_take  (load),
        .o_stat  (core_stat),
        .o_res   (core_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (load) begin
            n_out_valid = 1'b1;
            n_out       = core_res;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_ready     = core_stat.idle;
    assign o_out_valid    = r_out_valid;
    assign o_year         = r_out.year;
    assign o_month        = r_out.month;
    assign o_day_of_month = r_out.day_of_month;
    assign o_hour         = r_out.hour;
    assign o_minute       = r_out.minute;
    assign o_second       = r_out.second;
    assign o_weekday      = r_out.weekday;
    assign o_day_of_year  = r_out.day_of_year;

endmodule
`default_nettype wire

// File: sv/es2c_checker.sv
// Port-level checker for the epoch-to-calendar converter and its bind.
`default_nettype none
`include "epoch_seconds_to_calendar_top_defines.svh"
module es2c_checker
    import es2c_pkg::*;
#(
    parameter int SECONDS_BITS = SECONDS_BITS_DEF
) (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic [SECONDS_BITS-1:0] i_epoch_seconds,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [10:0]             o_year,
    input wire logic [3:0]              o_month,
    input wire logic [4:0]              o_day_of_month,
    input wire logic [4:0]              o_hour,
    input wire logic [5:0]              o_minute,
    input wire logic [5:0]              o_second,
    input wire logic [2:0]              o_weekday,
    input wire logic [8:0]              o_day_of_year
);

    logic        stalled;
    logic        in_range;
    logic [48:0] out_word;

    assign stalled  = o_out_valid && !i_out_ready;
    assign in_range = (o_month >= MONTH_JAN) && (o_month <= MONTH_DEC) &&
                      (o_day_of_month != 5'd0) && (o_hour <= 5'd23) &&
                      (o_minute <= 6'd59) && (o_second <= 6'd59) &&
                      (o_weekday <= 3'd6) && (o_day_of_year <= 9'd365) &&
                      (o_year >= EPOCH_YEAR);
    assign out_word = {o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                       o_weekday, o_day_of_year};

    // A word accepted at the input keeps the converter busy for at least the next cycle.
    `ES2C_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // An offered input word stays offered and unchanged until it is taken.
    `ES2C_ASSERT_NEXT(a_in_word_held, i_clk, i_rst_n, i_in_valid && !o_in_ready, i_in_valid && $stable(i_epoch_seconds))
    // Every delivered word carries calendar fields within their ranges.
    `ES2C_ASSERT_NOW(a_fields_in_range, i_clk, i_rst_n, o_out_valid, in_range)
    // A stalled output word stays valid.
    `ES2C_ASSERT_NEXT(a_out_valid_held, i_clk, i_rst_n, stalled, o_out_valid)
    // A stalled output word keeps its value.
    `ES2C_ASSERT_NEXT(a_out_word_held, i_clk, i_rst_n, stalled, $stable(out_word))

endmodule

bind epoch_seconds_to_calendar_top es2c_checker #(.SECONDS_BITS(SECONDS_BITS)) u_es2c_checker (.*);
`default_nettype wire

// File: bench/epoch_seconds_to_calendar_top_test.sv
// Self-checking testbench for the epoch seconds to calendar converter top level.
`default_nettype none
module epoch_seconds_to_calendar_top_test;
    import es2c_pkg::*;

    localparam int          SECS_W       = 31;
    localparam int          N_RANDOM     = 1000;
    // Near the end of the stimulus, and in one stretch in the middle, neither side idles.
    localparam int          QUIET_TAIL   = 150;
    localparam int          QUIET_LO     = 500;
    localparam int          QUIET_HI     = 600;
    // The receiver holds off once for this long after this many words have come out.
    localparam int          LONG_HOLD    = 400;
    localparam int          LONG_HOLD_AT = 100;
    // This drain outlasts the conversion of one word, so it covers any stray late word.
    localparam int          DRAIN_CYCLES = 200;
    // Slowest legal quiet stretch: one word plus the long hold-off plus a sender gap. The
    // limit is several times that.
    localparam int          STALL_LIMIT  = 4000;
    localparam int          MAX_PRINTS   = 40;
    localparam int unsigned DAY_SECS     = 86400;
    // Last whole day that still fits in 31 bits of seconds.
    localparam int unsigned LAST_DAY     = 24854;

    // Hand-picked instants: field extremes, minute, hour, day and year rollovers, the
    // weekend days of the first week, the leap day, the last day of a leap year (the
    // case where 365 but not 366 days remain), a 400-year leap day and the largest input.
    localparam logic [SECS_W-1:0] EDGE_CASES [24] = '{
        31'd0,         31'd1,         31'd59,        31'd60,
        31'd3599,      31'd3600,      31'd86399,     31'd86400,
        31'd172800,    31'd259200,    31'd31535999,  31'd31536000,
        31'd63071999,  31'd63072000,  31'd68169600,  31'd94607999,
        31'd94608000,  31'd94694399,  31'd94694400,  31'd951782400,
        31'd978220800, 31'h2AAAAAAA,  31'h55555555,  31'h7FFFFFFF
    };

    typedef struct {
        logic [SECS_W-1:0] secs;
        t_cal              cal;
    } t_date_due;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic [SECS_W-1:0] i_epoch_seconds = '0;
    logic              i_out_ready     = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [10:0]       o_year;
    logic [3:0]        o_month;
    logic [4:0]        o_day_of_month;
    logic [4:0]        o_hour;
    logic [5:0]        o_minute;
    logic [5:0]        o_second;
    logic [2:0]        o_weekday;
    logic [8:0]        o_day_of_year;

    // Seconds words waiting to be sent, and the dates owed for words already taken.
    logic [SECS_W-1:0] seconds_queue [$];
    t_date_due         dates_due [$];

    int                total_words    = 0;
    int                words_taken    = 0;
    int                bad_fields     = 0;
    int                send_gap       = 0;
    int                hold_left      = 0;
    int                words_received = 0;
    bit                held_long      = 1'b0;
    int                idle_cycles    = 0;

    always #6 i_clk = ~i_clk;

    epoch_seconds_to_calendar_top #(
        .SECONDS_BITS(SECS_W)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_epoch_seconds(i_epoch_seconds),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_year         (o_year),
        .o_month        (o_month),
        .o_day_of_month (o_day_of_month),
        .o_hour         (o_hour),
        .o_minute       (o_minute),
        .o_second       (o_second),
        .o_weekday      (o_weekday),
        .o_day_of_year  (o_day_of_year)
    );

    // Gregorian leap rule: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    endfunction

    // Breaks a seconds count into the calendar date and time of day.
    function automatic t_cal calendar_of(input logic [SECS_W-1:0] secs);
        t_cal        cal;
        int unsigned days;
        int unsigned tod;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        days = secs / DAY_SECS;
        tod  = secs % DAY_SECS;
        // The epoch fell on a Thursday.
        cal.weekday = 3'((4 + days % 7) % 7);
        // A year is stepped over only when its whole length remains.
        yr   = 1970;
        span = is_leap(yr) ? 366 : 365;
        while (days >= span) begin
            days -= span;
            yr++;
            span = is_leap(yr) ? 366 : 365;
        end
        cal.year        = 11'(yr);
        cal.day_of_year = 9'(days);
        mon = 1;
        forever begin
            case (mon)
                2:           span = is_leap(yr) ? 29 : 28;
                4, 6, 9, 11: span = 30;
                default:     span = 31;
            endcase
            if (mon >= 12 || days < span) break;
            days -= span;
            mon++;
        end
        cal.month        = 4'(mon);
        cal.day_of_month = 5'(days + 1);
        cal.hour         = 5'(tod / 3600);
        cal.minute       = 6'((tod % 3600) / 60);
        cal.second       = 6'(tod % 60);
        return cal;
    endfunction

    // True in the stretches of the run where neither side inserts idle cycles.
    function automatic bit calm_phase();
        return seconds_queue.size() < QUIET_TAIL ||
               (seconds_queue.size() >= QUIET_LO && seconds_queue.size() < QUIET_HI);
    endfunction

    task automatic flag_mismatch(input string what);
        if (bad_fields < MAX_PRINTS) $display("mismatch: %s", what);
        bad_fields++;
    endtask

    // Sender. A word stays offered, unchanged, until the block takes it. When the slot
    // is free the sender either starts a random idle burst or offers the next word. The
    // expected date is recorded at the edge that takes the word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                dates_due.push_back(t_date_due'{i_epoch_seconds, calendar_of(i_epoch_seconds)});
                words_taken++;
            end
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (seconds_queue.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!calm_phase() && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 15);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid      <= 1'b1;
                i_epoch_seconds <= seconds_queue.pop_front();
            end
        end
    end

    // Receiver. Ready drops in random bursts. Once, early on, it holds off for a long
    // stretch so that the output register fills, the sequencer waits in its done state
    // and the sender finds the input stalled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) words_received++;
            if (!held_long && words_received >= LONG_HOLD_AT) begin
                held_long = 1'b1;
                hold_left = LONG_HOLD - 1;
                i_out_ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (!calm_phase() && $urandom_range(0, 9) == 0) begin
                hold_left = $urandom_range(0, 15);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Checker. Every word taken from the output is matched against the oldest date due.
    always @(posedge i_clk) begin : check_dates
        t_date_due want;
        t_cal      got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_year, o_month, o_day_of_month, o_hour, o_minute, o_second,
                   o_weekday, o_day_of_year};
            if (dates_due.size() == 0) begin
                flag_mismatch($sformatf("word with no date due, year %0d month %0d day %0d",
                                        got.year, got.month, got.day_of_month));
            end else begin
                want = dates_due.pop_front();
                if (got.year !== want.cal.year)
                    flag_mismatch($sformatf("%0d s: year %0d, expected %0d",
                                            want.secs, got.year, want.cal.year));
                if (got.month !== want.cal.month)
                    flag_mismatch($sformatf("%0d s: month %0d, expected %0d",
                                            want.secs, got.month, want.cal.month));
                if (got.day_of_month !== want.cal.day_of_month)
                    flag_mismatch($sformatf("%0d s: day of month %0d, expected %0d",
                                            want.secs, got.day_of_month, want.cal.day_of_month));
                if (got.hour !== want.cal.hour)
                    flag_mismatch($sformatf("%0d s: hour %0d, expected %0d",
                                            want.secs, got.hour, want.cal.hour));
                if (got.minute !== want.cal.minute)
                    flag_mismatch($sformatf("%0d s: minute %0d, expected %0d",
                                            want.secs, got.minute, want.cal.minute));
                if (got.second !== want.cal.second)
                    flag_mismatch($sformatf("%0d s: second %0d, expected %0d",
                                            want.secs, got.second, want.cal.second));
                if (got.weekday !== want.cal.weekday)
                    flag_mismatch($sformatf("%0d s: weekday %0d, expected %0d",
                                            want.secs, got.weekday, want.cal.weekday));
                if (got.day_of_year !== want.cal.day_of_year)
                    flag_mismatch($sformatf("%0d s: day of year %0d, expected %0d",
                                            want.secs, got.day_of_year, want.cal.day_of_year));
            end
        end
    end

    // Watchdog. Any cycle in which neither channel moves a word counts toward the limit.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int unsigned year_day [69];
        int unsigned day;
        int unsigned offset;
        // Day number of January 1 of each year from 1970 to 2038.
        year_day[0] = 0;
        for (int k = 1; k < 69; k++)
            year_day[k] = year_day[k-1] + (is_leap(1969 + k) ? 366 : 365);

        foreach (EDGE_CASES[k]) seconds_queue.push_back(EDGE_CASES[k]);

        // Random words: a quarter spread over the whole range, a quarter on random days,
        // and half on the first or last day of a year, so that year ends, leap days and
        // month ends come up often. Times of day favor midnight and the last second.
        repeat (N_RANDOM) begin
            case ($urandom_range(0, 3))
                0:       offset = 0;
                1:       offset = DAY_SECS - 1;
                default: offset = $urandom_range(0, DAY_SECS - 1);
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    seconds_queue.push_back(SECS_W'($urandom()));
                end
                1: begin
                    day = $urandom_range(0, LAST_DAY);
                    seconds_queue.push_back(SECS_W'(day * DAY_SECS + offset));
                end
                default: begin
                    day = year_day[$urandom_range(1, 68)] - $urandom_range(0, 1);
                    seconds_queue.push_back(SECS_W'(day * DAY_SECS + offset));
                end
            endcase
        end
        total_words = seconds_queue.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All words taken, then all dates delivered, then a quiet drain for stray words.
        while (words_taken != total_words) @(posedge i_clk);
        while (dates_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_fields == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
